@@ src/weekly_alarm_table_scheduler_defines.svh @@
// ---------------------------------------------------------------------------
// Weekly alarm table scheduler: assertion macros
// Shared assertion forms for the scheduler, clocked on i_clk and held off
// while the synchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef WEEKLY_ALARM_TABLE_SCHEDULER_DEFINES_SVH
`define WEEKLY_ALARM_TABLE_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WATS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define WATS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed one cycle later");

`endif

@@ src/wats_pkg.sv @@
// ---------------------------------------------------------------------------
// Weekly alarm table scheduler package
// Types, constants and helper functions shared by the scheduler modules.
// ---------------------------------------------------------------------------
package wats_pkg;

    // Field widths of one table entry.
    localparam int TIME_W  = 11;
    localparam int LEVEL_W = 7;
    localparam int DAYS_W  = 7;

    // Scheduling constants.
    localparam int MIN_PER_HOUR = 60;
    localparam int LEVEL_MAX    = 100;
    localparam int LEVEL_STEP   = 5;
    localparam int ROUND_UP_REM = 3;
    localparam int MAX_RESULTS  = 8;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    // Reciprocal of the level step, valid for levels up to LEVEL_MAX.
    localparam int RECIP_MUL   = 205;
    localparam int RECIP_SHIFT = 10;

    // Command codes carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_SYNC  = 2'd2,
        CMD_CATCH = 2'd3
    } t_cmd;

    // Operand pairs that the shared comparator can be asked to check.
    typedef enum logic [1:0] {
        CMP_NOW  = 2'd0,   // entry time <= current time
        CMP_BEST = 2'd1,   // entry time <= best candidate time
        CMP_LAST = 2'd2    // best candidate time <= last applied time
    } t_cmp_sel;

    // One stored alarm entry.
    typedef struct packed {
        logic               active;
        logic [DAYS_W-1:0]  days;
        logic [TIME_W-1:0]  minutes;
        logic [LEVEL_W-1:0] level;
    } t_entry;

    // Operands offered to the shared comparator.
    typedef struct packed {
        logic [TIME_W-1:0] entry_time;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] best_time;
        logic [TIME_W-1:0] last_now;
    } t_cmp_ops;

    // Minutes since midnight, without wrapping of out-of-range fields.
    function automatic logic [TIME_W-1:0] to_minutes(input logic [4:0] hour,
                                                     input logic [5:0] minute);
        return TIME_W'(hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(minute);
    endfunction

    // Clamp to 0..100 and round to the level step; remainders 3 and 4 go up.
    function automatic logic [LEVEL_W-1:0] round_level(input logic signed [7:0] raw);
        logic [LEVEL_W-1:0] v;
        logic [15:0]        prod;
        logic [LEVEL_W-1:0] quot;
        logic [LEVEL_W-1:0] rem;
        if (raw[7]) begin
            v = '0;
        end else if (raw > 8'sd100) begin
            v = LEVEL_W'(LEVEL_MAX);
        end else begin
            v = raw[LEVEL_W-1:0];
        end
        prod = 16'(v) * 16'(RECIP_MUL);
        quot = LEVEL_W'(prod >> RECIP_SHIFT);
        rem  = v - LEVEL_W'(quot * LEVEL_W'(LEVEL_STEP));
        return v - rem + ((rem >= LEVEL_W'(ROUND_UP_REM)) ? LEVEL_W'(LEVEL_STEP) : '0);
    endfunction

endpackage

@@ src/weekly_alarm_table_scheduler.sv @@
// ---------------------------------------------------------------------------
// Weekly alarm table scheduler
// Keeps a table of weekly alarm entries and walks it under a small sequencer
// for minute ticks, fired-flag sync and catch-up after a reload.
// ---------------------------------------------------------------------------
// Channel   Direction  Signals                      Contents
// s_axis    in         tvalid tready tdata tuser    command and entry/time fields
// m_axis    out        tvalid tready tdata tlast    fired slot and level
//
// A write goes to the table straight from the idle state. Tick and sync visit each
// slot with a table read step and then a compare step, between the accepting and
// closing states; catch-up adds a best-candidate step for a matching slot once a
// candidate is held, as a second pass through the shared comparator picks the latest.
// Each result waits for the output register to be free; the walk pauses there.
// Reset clears the valid bits of the table and all fired flags.
// The input is not ready until the walk of the previous item has finished.
// ---------------------------------------------------------------------------
`include "weekly_alarm_table_scheduler_defines.svh"

module weekly_alarm_table_scheduler
    import wats_pkg::*;
#(
    parameter int ENTRY_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: entry_index[2:0], active[3], day_mask[10:4],
    // raw_level[18:11], day[21:19], hour[26:22], minute[32:27],
    // last_day[35:33], last_hour[40:36], last_minute[46:41], zero fill[47]
    input  logic [47:0] s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: fired_index[2:0], target_level[9:3], zero fill[15:10]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_BEST = 5'b01000,
        S_END  = 5'b10000
    } t_state;

    // Unpacked input fields
    t_cmd               in_cmd;
    logic [2:0]         in_entry_index;
    logic               in_active;
    logic [DAYS_W-1:0]  in_day_mask;
    logic signed [7:0]  in_raw_level;
    logic [2:0]         in_day;
    logic [4:0]         in_hour;
    logic [5:0]         in_minute;
    logic [2:0]         in_last_day;
    logic [4:0]         in_last_hour;
    logic [5:0]         in_last_minute;

    // Sequencer state and captured command
    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [2:0]             r_day, n_day;
    logic [2:0]             r_last_day, n_last_day;
    logic [TIME_W-1:0]      r_now, n_now;
    logic [TIME_W-1:0]      r_last_now, n_last_now;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [ENTRY_COUNT-1:0] r_fired, n_fired;

    // Pending result or best catch-up candidate
    logic                   r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic [LEVEL_W-1:0]     r_pend_level, n_pend_level;
    logic [TIME_W-1:0]      r_pend_time, n_pend_time;

    // Output register
    logic                   r_out_valid, n_out_valid;
    logic [2:0]             r_out_idx, n_out_idx;
    logic [LEVEL_W-1:0]     r_out_level, n_out_level;
    logic                   r_out_last, n_out_last;

    // Table and comparator connections
    logic                   accept;
    logic                   wr_en;
    t_entry                 wr_data;
    t_entry                 rd_entry;
    t_cmp_sel               cmp_sel;
    t_cmp_ops               cmp_ops;
    logic                   cmp_le;
    logic [7:0]             day_bits;
    logic                   today;
    logic                   last_entry;
    logic                   out_free;
    logic                   adv;
    logic                   emit;

    // Unpack the input transfer
    assign in_cmd         = t_cmd'(s_axis_tuser);
    assign in_entry_index = s_axis_tdata[2:0];
    assign in_active      = s_axis_tdata[3];
    assign in_day_mask    = s_axis_tdata[10:4];
    assign in_raw_level   = s_axis_tdata[18:11];
    assign in_day         = s_axis_tdata[21:19];
    assign in_hour        = s_axis_tdata[26:22];
    assign in_minute      = s_axis_tdata[32:27];
    assign in_last_day    = s_axis_tdata[35:33];
    assign in_last_hour   = s_axis_tdata[40:36];
    assign in_last_minute = s_axis_tdata[46:41];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Table write for a write command to a slot that exists
    assign wr_en = accept && (in_cmd == CMD_WRITE) && (32'(in_entry_index) < ENTRY_COUNT);
    always_comb begin
        wr_data.active  = in_active;
        wr_data.days    = in_day_mask;
        wr_data.minutes = to_minutes(in_hour, in_minute);
        wr_data.level   = round_level(in_raw_level);
    end

    wats_table #(
        .ENTRY_COUNT(ENTRY_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(in_entry_index)),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_entry)
    );

    // Comparator operands follow the sequencer step
    always_comb begin
        unique case (r_state)
            S_EVAL:  cmp_sel = CMP_NOW;
            S_BEST:  cmp_sel = CMP_BEST;
            default: cmp_sel = CMP_LAST;
        endcase
        cmp_ops.entry_time = rd_entry.minutes;
        cmp_ops.now        = r_now;
        cmp_ops.best_time  = r_pend_time;
        cmp_ops.last_now   = r_last_now;
    end

    wats_cmp u_cmp (
        .i_sel (cmp_sel),
        .i_ops (cmp_ops),
        .o_le  (cmp_le)
    );

    // Weekday seven has no mask bit, so it reads the zero fill.
    assign day_bits   = {1'b0, rd_entry.days};
    assign today      = day_bits[r_day];
    assign last_entry = (r_idx == IDX_W'(ENTRY_COUNT - 1));
    assign out_free   = !r_out_valid || m_axis_tready;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_day        = r_day;
        n_last_day   = r_last_day;
        n_now        = r_now;
        n_last_now   = r_last_now;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_fired      = r_fired;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_level = r_pend_level;
        n_pend_time  = r_pend_time;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_idx    = r_out_idx;
        n_out_level  = r_out_level;
        n_out_last   = r_out_last;
        adv          = 1'b0;
        emit         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (in_cmd != CMD_WRITE)) begin
                    n_cmd        = in_cmd;
                    n_day        = in_day;
                    n_last_day   = in_last_day;
                    n_now        = to_minutes(in_hour, in_minute);
                    n_last_now   = to_minutes(in_last_hour, in_last_minute);
                    n_idx        = '0;
                    n_cnt        = '0;
                    n_pend_valid = 1'b0;
                    n_state      = S_READ;
                    // Midnight tick starts a new day of firing.
                    if ((in_cmd == CMD_TICK) && (in_hour == 5'd0) && (in_minute == 6'd0)) begin
                        n_fired = '0;
                    end
                end
            end

            S_READ: begin
                n_state = S_EVAL;
            end

            S_EVAL: begin
                unique case (r_cmd)
                    CMD_TICK: begin
                        if (rd_entry.active && today && !r_fired[r_idx] && cmp_le
                            && (r_cnt < CNT_W'(MAX_RESULTS))) begin
                            // Hand the older pending result on before taking this one.
                            if (!r_pend_valid || out_free) begin
                                if (r_pend_valid) begin
                                    n_out_valid = 1'b1;
                                    n_out_idx   = 3'(r_pend_idx);
                                    n_out_level = r_pend_level;
                                    n_out_last  = 1'b0;
                                end
                                n_pend_valid     = 1'b1;
                                n_pend_idx       = r_idx;
                                n_pend_level     = rd_entry.level;
                                n_pend_time      = rd_entry.minutes;
                                n_fired[r_idx]   = 1'b1;
                                n_cnt            = r_cnt + 1'b1;
                                adv              = 1'b1;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    CMD_SYNC: begin
                        if (today) begin
                            n_fired[r_idx] = cmp_le;
                        end
                        adv = 1'b1;
                    end
                    CMD_CATCH: begin
                        if (rd_entry.active && today && cmp_le) begin
                            n_fired[r_idx] = 1'b1;
                            if (!r_pend_valid) begin
                                n_pend_valid = 1'b1;
                                n_pend_idx   = r_idx;
                                n_pend_level = rd_entry.level;
                                n_pend_time  = rd_entry.minutes;
                                adv          = 1'b1;
                            end else begin
                                n_state = S_BEST;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_BEST: begin
                // Strictly later time replaces the candidate; ties keep the lower slot.
                if (!cmp_le) begin
                    n_pend_idx   = r_idx;
                    n_pend_level = rd_entry.level;
                    n_pend_time  = rd_entry.minutes;
                end
                adv = 1'b1;
            end

            S_END: begin
                // Final result carries the last flag.
                if (r_cmd == CMD_TICK) begin
                    emit = r_pend_valid;
                end else if (r_cmd == CMD_CATCH) begin
                    emit = r_pend_valid && ((r_last_day != r_day) || !cmp_le);
                end
                if (!emit) begin
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = 3'(r_pend_idx);
                    n_out_level  = r_pend_level;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Step to the next slot, or close the walk after the last one.
        if (adv) begin
            if (last_entry) begin
                n_state = S_END;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = S_READ;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_fired      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_fired      <= n_fired;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_day        <= n_day;
        r_last_day   <= n_last_day;
        r_now        <= n_now;
        r_last_now   <= n_last_now;
        r_pend_idx   <= n_pend_idx;
        r_pend_level <= n_pend_level;
        r_pend_time  <= n_pend_time;
        r_out_idx    <= n_out_idx;
        r_out_level  <= n_out_level;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_level, r_out_idx};
    assign m_axis_tlast  = r_out_last;

    // Checks on the sequencer
    `WATS_ASSERT_NEXT(a_busy_after_cmd, accept && (in_cmd != CMD_WRITE), !s_axis_tready)
    `WATS_ASSERT_SAME(a_idle_no_pending, r_state == S_IDLE, !r_pend_valid)
    `WATS_ASSERT_SAME(a_count_bounded, r_state != S_IDLE, r_cnt <= CNT_W'(MAX_RESULTS))

endmodule

@@ src/wats_cmp.sv @@
// ---------------------------------------------------------------------------
// Shared time comparator
// Selects one operand pair by code and reports whether the first operand is
// at or before the second.
// ---------------------------------------------------------------------------
module wats_cmp
    import wats_pkg::*;
(
    input  t_cmp_sel i_sel,
    input  t_cmp_ops i_ops,
    output logic     o_le
);

    logic [TIME_W-1:0] op_a;
    logic [TIME_W-1:0] op_b;

    // Operand selection for the current step of the sequencer.
    always_comb begin
        unique case (i_sel)
            CMP_NOW: begin
                op_a = i_ops.entry_time;
                op_b = i_ops.now;
            end
            CMP_BEST: begin
                op_a = i_ops.entry_time;
                op_b = i_ops.best_time;
            end
            CMP_LAST: begin
                op_a = i_ops.best_time;
                op_b = i_ops.last_now;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The single magnitude compare.
    assign o_le = (op_a <= op_b);

endmodule

@@ src/wats_table.sv @@
// ---------------------------------------------------------------------------
// Alarm entry table
// Single-port-write, registered-read store of the alarm entries, with a
// valid bit per slot so that unwritten slots read as all zeros.
// ---------------------------------------------------------------------------
module wats_table
    import wats_pkg::*;
#(
    parameter  int ENTRY_COUNT = 8,
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry                 r_mem [ENTRY_COUNT];
    t_entry                 r_rd_data;
    logic [ENTRY_COUNT-1:0] r_valid;
    logic                   r_rd_valid;

    // Entry storage: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Valid bits, cleared at reset and set by the first write to a slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // A slot that was never written reads as all zeros.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
